/* rtl/otnl_pkg.sv */
// ----------------------------------------------------------------------------
// otnl_pkg: shared types and constants for the nearest landmark unit
// Payload structs, configuration register codes, controller commands and
// datapath status used across the block.
// ----------------------------------------------------------------------------
package otnl_pkg;

  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 24;
  localparam int COUNT_W       = 7;
  // Table depth; the slot and count fields below are sized for it.
  localparam int MAX_LANDMARKS = 64;

  localparam logic signed [23:0] POSE_X_RST = 24'sd0;
  localparam logic signed [23:0] POSE_Y_RST = 24'sd0;
  localparam logic signed [15:0] COS_RST    = 16'sd16384;
  localparam logic signed [15:0] SIN_RST    = 16'sd0;
  localparam logic [COUNT_W-1:0] COUNT_RST  = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POSE_X      = 3'd0,
    CFG_POSE_Y      = 3'd1,
    CFG_COS_HEADING = 3'd2,
    CFG_SIN_HEADING = 3'd3,
    CFG_LM_COUNT    = 3'd4
  } cfg_idx_t;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_OBS  = 1'b1
  } func_t;

  typedef struct packed {
    logic              func;
    logic [5:0]        slot;
    logic signed [23:0] mark_x;
    logic signed [23:0] mark_y;
    logic [15:0]       mark_id;
    logic signed [23:0] obs_x;
    logic signed [23:0] obs_y;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] map_x;
    logic signed [23:0] map_y;
    logic [5:0]        best_slot;
    logic [15:0]       best_id;
    logic [49:0]       best_dist_sq;
    logic              valid_res;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_P0,
    ST_P1,
    ST_P2,
    ST_P3,
    ST_P4,
    ST_P5,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  typedef enum logic [1:0] {
    MS_C_OX,
    MS_S_OY,
    MS_S_OX,
    MS_C_OY
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef struct packed {
    logic               mark_wr;
    logic               obs_load;
    mul_sel_t           mul_sel;
    acc_op_t            acc_op;
    logic               map_x_ld;
    logic               map_y_ld;
    logic               rd_en;
    logic [COUNT_W-1:0] rd_idx;
    logic               out_ld;
  } ctl_cmd_t;

  typedef struct packed {
    logic [COUNT_W-1:0] scan_n;
    logic               pipe_busy;
  } dp_stat_t;

endpackage

/* rtl/otnl_ram.sv */
// ----------------------------------------------------------------------------
// otnl_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module otnl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]   waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]   raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/otnl_ctrl.sv */
// ----------------------------------------------------------------------------
// otnl_ctrl: sequencer for the nearest landmark unit
// Steps the shared rotation multiplier, issues the landmark scan and hands
// the finished result to the output register.
// ----------------------------------------------------------------------------
module otnl_ctrl
  import otnl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     in_func,
  output logic     out_valid,
  input  logic     out_ready,
  output ctl_cmd_t cmd,
  input  dp_stat_t stat
);

  state_t             state_r, state_nxt;
  logic [COUNT_W-1:0] idx_r, idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.mul_sel  = MS_C_OX;
    cmd.acc_op   = ACC_HOLD;
    cmd.rd_idx   = idx_r;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (func_t'(in_func) == FUNC_OBS) begin
            cmd.obs_load = 1'b1;
            state_nxt    = ST_P0;
          end else begin
            cmd.mark_wr = 1'b1;
          end
        end
      end
      ST_P0: begin
        cmd.mul_sel = MS_C_OX;
        state_nxt   = ST_P1;
      end
      ST_P1: begin
        cmd.mul_sel = MS_S_OY;
        cmd.acc_op  = ACC_LOAD;
        state_nxt   = ST_P2;
      end
      ST_P2: begin
        cmd.mul_sel = MS_S_OX;
        cmd.acc_op  = ACC_SUB;
        state_nxt   = ST_P3;
      end
      ST_P3: begin
        cmd.mul_sel  = MS_C_OY;
        cmd.acc_op   = ACC_LOAD;
        cmd.map_x_ld = 1'b1;
        state_nxt    = ST_P4;
      end
      ST_P4: begin
        cmd.acc_op = ACC_ADD;
        state_nxt  = ST_P5;
      end
      ST_P5: begin
        cmd.map_y_ld = 1'b1;
        idx_nxt      = '0;
        state_nxt    = (stat.scan_n == '0) ? ST_DRAIN : ST_SCAN;
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        idx_nxt   = idx_r + 1'b1;
        if (idx_nxt == stat.scan_n) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy && out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

endmodule

/* rtl/otnl_datapath.sv */
// ----------------------------------------------------------------------------
// otnl_datapath: transform and nearest-landmark search datapath
// Configuration registers, the landmark table, the shared rotation
// multiplier and the four-stage distance pipeline with its running minimum.
// ----------------------------------------------------------------------------
module otnl_datapath
  import otnl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  in_item_t              in_data,
  input  ctl_cmd_t              cmd,
  output dp_stat_t              stat,
  output out_item_t             out_data
);

  localparam int AW       = $clog2(MAX_LANDMARKS > 1 ? MAX_LANDMARKS : 2);
  localparam int MAX_CLIP = (MAX_LANDMARKS < 127) ? MAX_LANDMARKS : 127;

  // Configuration registers.
  logic signed [23:0] pose_x_r, pose_y_r;
  logic signed [15:0] cos_r, sin_r;
  logic [COUNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pose_x_r <= POSE_X_RST;
      pose_y_r <= POSE_Y_RST;
      cos_r    <= COS_RST;
      sin_r    <= SIN_RST;
      count_r  <= COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_POSE_X:      pose_x_r <= cfg_data[23:0];
        CFG_POSE_Y:      pose_y_r <= cfg_data[23:0];
        CFG_COS_HEADING: cos_r    <= cfg_data[15:0];
        CFG_SIN_HEADING: sin_r    <= cfg_data[15:0];
        CFG_LM_COUNT:    count_r  <= cfg_data[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign stat.scan_n = (int'(count_r) > MAX_CLIP) ? COUNT_W'(MAX_CLIP) : count_r;

  // Landmark table: x, y and id packed in one word.
  logic           slot_ok;
  logic [63:0]    rdata;
  logic [AW-1:0]  waddr, raddr;

  assign slot_ok = int'(in_data.slot) < MAX_LANDMARKS;
  assign waddr   = AW'(in_data.slot);
  assign raddr   = AW'(cmd.rd_idx);

  otnl_ram #(
    .WIDTH (64),
    .DEPTH (MAX_LANDMARKS)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.mark_wr && slot_ok),
    .waddr (waddr),
    .wdata ({in_data.mark_x, in_data.mark_y, in_data.mark_id}),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Rotation: one shared multiplier, four products in turn.
  logic signed [23:0] obs_x_r, obs_y_r;
  logic signed [15:0] mul_a;
  logic signed [23:0] mul_b;
  logic signed [39:0] prod_r;
  logic signed [40:0] acc_r, acc_nxt, prod_ext;
  logic signed [23:0] map_x_r, map_y_r, map_sat;

  always_ff @(posedge clk) begin
    if (cmd.obs_load) begin
      obs_x_r <= in_data.obs_x;
      obs_y_r <= in_data.obs_y;
    end
  end

  always_comb begin
    case (cmd.mul_sel)
      MS_C_OX: begin mul_a = cos_r; mul_b = obs_x_r; end
      MS_S_OY: begin mul_a = sin_r; mul_b = obs_y_r; end
      MS_S_OX: begin mul_a = sin_r; mul_b = obs_x_r; end
      default: begin mul_a = cos_r; mul_b = obs_y_r; end
    endcase
  end

  assign prod_ext = {prod_r[39], prod_r};

  always_comb begin
    case (cmd.acc_op)
      ACC_LOAD: acc_nxt = prod_ext;
      ACC_ADD:  acc_nxt = acc_r + prod_ext;
      ACC_SUB:  acc_nxt = acc_r - prod_ext;
      default:  acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    acc_r  <= acc_nxt;
  end

  // Round half up to 8 fraction bits, add the pose and clamp to 24 bits.
  function automatic logic signed [23:0] to_map(input logic signed [40:0] acc,
                                                input logic signed [23:0] pose);
    logic signed [40:0] r;
    logic signed [27:0] s;
    r = acc + 41'sd8192;
    s = {{4{pose[23]}}, pose} + {r[40], r[40:14]};
    if (s > 28'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (s < -28'sd8388608) begin
      return 24'sh800000;
    end
    return s[23:0];
  endfunction

  assign map_sat = to_map(acc_r, cmd.map_x_ld ? pose_x_r : pose_y_r);

  always_ff @(posedge clk) begin
    if (cmd.map_x_ld) begin
      map_x_r <= map_sat;
    end
    if (cmd.map_y_ld) begin
      map_y_r <= map_sat;
    end
  end

  // Distance pipeline: table read, difference, squares, sum and compare.
  logic                a_v_r, d_v_r, s_v_r;
  logic [5:0]          a_idx_r, d_idx_r, s_idx_r;
  logic signed [23:0]  rd_x, rd_y;
  logic signed [24:0]  dx_r, dy_r;
  logic [15:0]         d_id_r, s_id_r;
  logic signed [49:0]  sqx_full, sqy_full;
  logic [47:0]         sqx_r, sqy_r;
  logic [48:0]         dist_sum, best_d_r;
  logic [5:0]          best_idx_r;
  logic [15:0]         best_id_r;
  logic                found_r, take;

  assign rd_x     = rdata[63:40];
  assign rd_y     = rdata[39:16];
  assign sqx_full = dx_r * dx_r;
  assign sqy_full = dy_r * dy_r;
  assign dist_sum = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign take     = s_v_r && (!found_r || dist_sum < best_d_r);

  assign stat.pipe_busy = a_v_r || d_v_r || s_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      d_v_r   <= 1'b0;
      s_v_r   <= 1'b0;
      found_r <= 1'b0;
    end else begin
      a_v_r <= cmd.rd_en;
      d_v_r <= a_v_r;
      s_v_r <= d_v_r;
      if (cmd.obs_load) begin
        found_r <= 1'b0;
      end else if (take) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_idx_r <= cmd.rd_idx[5:0];
    d_idx_r <= a_idx_r;
    d_id_r  <= rdata[15:0];
    dx_r    <= {rd_x[23], rd_x} - {map_x_r[23], map_x_r};
    dy_r    <= {rd_y[23], rd_y} - {map_y_r[23], map_y_r};
    s_idx_r <= d_idx_r;
    s_id_r  <= d_id_r;
    sqx_r   <= sqx_full[47:0];
    sqy_r   <= sqy_full[47:0];
    if (take) begin
      best_d_r   <= dist_sum;
      best_idx_r <= s_idx_r;
      best_id_r  <= s_id_r;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_data.map_x        <= map_x_r;
      out_data.map_y        <= map_y_r;
      out_data.best_slot    <= found_r ? best_idx_r : 6'd0;
      out_data.best_id      <= found_r ? best_id_r : 16'd0;
      out_data.best_dist_sq <= found_r ? {1'b0, best_d_r} : 50'd0;
      out_data.valid_res    <= found_r;
    end
  end

endmodule

/* rtl/observation_to_nearest_landmark_unit.sv */
// ----------------------------------------------------------------------------
// observation_to_nearest_landmark_unit: nearest landmark association
// Transforms a vehicle-frame observation into map coordinates and finds the
// closest stored landmark by squared distance.
// ----------------------------------------------------------------------------
// Usage. The input channel carries two kinds of transfer. A load transfer
// (func = 0) writes x, y and id into one table slot and produces no result,
// and a slot beyond the table is dropped. An observation transfer (func = 1)
// is rotated by the cosine and sine registers, shifted by the pose registers
// and saturated, then compared against slots 0 up to landmark_count - 1
// (capped at the table depth). The controller steps the single 16x24
// multiplier through the four rotation products, reads one table word per
// searched slot from the landmark RAM, flushes the read, difference and
// square stages into the running minimum and then loads the output
// register. A new item is taken the cycle after the result is parked in the
// output register; no item is taken while an observation is in flight.
// When the receiver stalls, the result waits in the output register; the
// next observation runs and holds in its last step until that register is
// freed. Reset clears the control state and loads the register defaults;
// the landmark table is not cleared, so every slot that is searched must be
// loaded first. The configuration port is always ready.
module observation_to_nearest_landmark_unit
  import otnl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // Register writes never stall.
  assign cfg_ready = 1'b1;

  otnl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_func   (in_data.func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  otnl_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

/* rtl/otnl_checker.sv */
// ----------------------------------------------------------------------------
// otnl_checker: port-level checks for the nearest landmark unit
// Watches the top-level channels and flags protocol and result slips.
// ----------------------------------------------------------------------------
module otnl_checker
  import otnl_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data,
  input logic      cfg_ready
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // An observation transfer occupies the block for the following cycle.
  a_obs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.func |=> !in_ready)
    else $error("input taken right after an observation");

  // An empty search reports zero slot, id and distance.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.valid_res |->
      out_data.best_slot == 6'd0 && out_data.best_id == 16'd0 &&
      out_data.best_dist_sq == 50'd0)
    else $error("empty search carries nonzero fields");

  // Register writes are never stalled.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("configuration port stalled");

endmodule

bind observation_to_nearest_landmark_unit otnl_checker u_otnl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_ready (cfg_ready)
);

/* test/tb_observation_to_nearest_landmark_unit.sv */
// ----------------------------------------------------------------------------
// tb_observation_to_nearest_landmark_unit: nearest landmark association test
// Drives load and observation transfers into the unit, predicts every result
// from a local copy of the pose, heading, count and landmark table, and
// checks each result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_observation_to_nearest_landmark_unit
  import otnl_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int     MAX_SLOTS     = 64;
  localparam int     RESET_CYCLES  = 8;
  // The settle pause covers the longest observation, a 64-slot search, with margin.
  localparam int     SETTLE_CYCLES = 100;
  localparam int     HOLD_CYCLES   = 300;
  localparam int     PHASES        = 8;
  localparam int     PHASE_ITEMS   = 65;
  localparam longint CYCLE_LIMIT   = 400000;
  localparam longint COORD_HI      = 64'sd8388607;
  localparam longint COORD_LO      = -64'sd8388608;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Local copy of the unit's registers and landmark table, updated at the
  // moment each transfer is accepted so that ordering matches the hardware.
  logic signed [23:0] p_pose_x;
  logic signed [23:0] p_pose_y;
  logic signed [15:0] p_cos;
  logic signed [15:0] p_sin;
  logic [6:0]         p_count;
  logic signed [23:0] tbl_x  [MAX_SLOTS];
  logic signed [23:0] tbl_y  [MAX_SLOTS];
  logic [15:0]        tbl_id [MAX_SLOTS];

  // Predicted association results still waiting for their result transfer.
  out_item_t pending_assoc[$];
  out_item_t want_item;

  int     error_count = 0;
  longint cycle_count = 0;
  int     hold_left   = 0;
  bit     calm_phase  = 1'b0;

  observation_to_nearest_landmark_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The run is bounded by a plain cycle counter; a hang of any kind ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Every mismatch goes through here: one line, one count.
  task automatic report_mismatch(input string what, input logic [63:0] exp_v,
                                 input logic [63:0] got_v);
    $display("mismatch at cycle %0d: %s expected %0h got %0h",
             cycle_count, what, exp_v, got_v);
    error_count++;
  endtask

  // Round a Q.22 rotation product sum to 8 fraction bits, half toward +inf.
  // The shift on a signed longint is arithmetic, which floors.
  function automatic longint round_q14(input longint acc);
    return (acc + 64'sd8192) >>> 14;
  endfunction

  function automatic longint clamp_coord(input longint v);
    if (v > COORD_HI) return COORD_HI;
    if (v < COORD_LO) return COORD_LO;
    return v;
  endfunction

  // Transform one observation into the map frame and search the loaded
  // slots for the smallest squared distance. The strict less-than keeps
  // the lowest slot when two landmarks are equally near.
  function automatic out_item_t associate_obs(input in_item_t item);
    longint      ox, oy, c, s, mx, my, dx, dy;
    logic [49:0] dsq;
    int          n;
    out_item_t   res;
    ox  = longint'($signed(item.obs_x));
    oy  = longint'($signed(item.obs_y));
    c   = longint'(p_cos);
    s   = longint'(p_sin);
    mx  = clamp_coord(longint'(p_pose_x) + round_q14(c * ox - s * oy));
    my  = clamp_coord(longint'(p_pose_y) + round_q14(s * ox + c * oy));
    res = '0;
    res.map_x = mx[23:0];
    res.map_y = my[23:0];
    // A count above the table depth searches the whole table.
    n = (int'(p_count) > MAX_SLOTS) ? MAX_SLOTS : int'(p_count);
    for (int i = 0; i < n; i++) begin
      dx  = longint'(tbl_x[i]) - mx;
      dy  = longint'(tbl_y[i]) - my;
      dsq = 50'(dx * dx + dy * dy);
      if (!res.valid_res || dsq < res.best_dist_sq) begin
        res.valid_res    = 1'b1;
        res.best_slot    = i[5:0];
        res.best_id      = tbl_id[i];
        res.best_dist_sq = dsq;
      end
    end
    return res;
  endfunction

  // Fields that an item's func does not use are filled with noise so the
  // unit is seen to ignore them.
  function automatic in_item_t make_load(input logic [5:0] slot, input logic [23:0] x,
                                         input logic [23:0] y, input logic [15:0] id);
    in_item_t item;
    item.func    = FUNC_LOAD;
    item.slot    = slot;
    item.mark_x  = x;
    item.mark_y  = y;
    item.mark_id = id;
    item.obs_x   = 24'($urandom());
    item.obs_y   = 24'($urandom());
    return item;
  endfunction

  function automatic in_item_t make_obs(input logic [23:0] x, input logic [23:0] y);
    in_item_t item;
    item.func    = FUNC_OBS;
    item.slot    = 6'($urandom());
    item.mark_x  = 24'($urandom());
    item.mark_y  = 24'($urandom());
    item.mark_id = 16'($urandom());
    item.obs_x   = x;
    item.obs_y   = y;
    return item;
  endfunction

  // Either any 24-bit coordinate or one within a small cluster around the
  // origin, where landmarks compete and ties become likely.
  function automatic logic [23:0] rand_coord(input bit wide);
    if (wide) return 24'($urandom());
    return 24'(int'($urandom_range(0, 8191)) - 4096);
  endfunction

  // Send one item on the input channel. Called at a falling edge and
  // returns at a falling edge with in_valid low. The prediction is taken
  // at the accepting edge, so loads and observations keep their order.
  task automatic send_item(input in_item_t item);
    if (!calm_phase && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_data  = item;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (item.func == FUNC_LOAD) begin
      tbl_x[item.slot]  = item.mark_x;
      tbl_y[item.slot]  = item.mark_y;
      tbl_id[item.slot] = item.mark_id;
    end else begin
      pending_assoc.insert(pending_assoc.size(), associate_obs(item));
    end
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Write one register and mirror it into the local copy. Only called
  // while the unit is idle.
  task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_index = idx;
    cfg_data  = value;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_POSE_X:      p_pose_x = value[23:0];
      CFG_POSE_Y:      p_pose_y = value[23:0];
      CFG_COS_HEADING: p_cos    = value[15:0];
      CFG_SIN_HEADING: p_sin    = value[15:0];
      CFG_LM_COUNT:    p_count  = value[6:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Pause the sender until every predicted result has been seen, then give
  // the unit time to finish anything that produces no result.
  task automatic quiesce();
    while (pending_assoc.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Receiver: random stall bursts, a long hold-off when a test asks for one,
  // and a steady ready during the calm final phase.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(0, 4)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Result checker: each result transfer is compared with the oldest
  // prediction, one field at a time.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_assoc.size() == 0) begin
        report_mismatch("result with nothing pending, map_x", '0, out_data.map_x);
      end else begin
        want_item = pending_assoc.pop_front();
        if (out_data.map_x !== want_item.map_x)
          report_mismatch("map_x", want_item.map_x, out_data.map_x);
        if (out_data.map_y !== want_item.map_y)
          report_mismatch("map_y", want_item.map_y, out_data.map_y);
        if (out_data.best_slot !== want_item.best_slot)
          report_mismatch("best_slot", want_item.best_slot, out_data.best_slot);
        if (out_data.best_id !== want_item.best_id)
          report_mismatch("best_id", want_item.best_id, out_data.best_id);
        if (out_data.best_dist_sq !== want_item.best_dist_sq)
          report_mismatch("best_dist_sq", want_item.best_dist_sq, out_data.best_dist_sq);
        if (out_data.valid_res !== want_item.valid_res)
          report_mismatch("valid_res", want_item.valid_res, out_data.valid_res);
      end
    end
  end

  // With the reset defaults the count is zero, so every observation comes
  // back with no landmark but with the transformed point; an identity
  // heading and zero pose must return the observation unchanged.
  task automatic test_empty_table();
    send_item(make_obs(24'h000000, 24'h000000));
    send_item(make_obs(24'h7FFFFF, 24'h800000));
    send_item(make_obs(24'h800000, 24'h7FFFFF));
  endtask

  // Only slots 0..5 are ever searched here; slot 63 is loaded but left out
  // of the search range.
  task automatic test_nearest_search();
    send_item(make_load(6'd0, 24'd100, 24'd100, 16'h0000));
    send_item(make_load(6'd1, 24'h800000, 24'h800000, 16'hFFFF));
    send_item(make_load(6'd2, 24'h7FFFFF, 24'h7FFFFF, 16'hA5A5));
    send_item(make_load(6'd3, 24'h123456, 24'(-5000), 16'h5A5A));
    // Slots 4 and 5 share a position: a tie must resolve to slot 4.
    send_item(make_load(6'd4, 24'd2560, 24'd2560, 16'd7));
    send_item(make_load(6'd5, 24'd2560, 24'd2560, 16'd8));
    send_item(make_load(6'd63, 24'h7FFFFF, 24'h800000, 16'hFFFF));
    quiesce();
    cfg_write(CFG_LM_COUNT, 24'd6);
    send_item(make_obs(24'h123456, 24'(-5000)));
    send_item(make_obs(24'd2560, 24'd2560));
    send_item(make_obs(24'h7FFFFF, 24'h7FFFFF));
    send_item(make_obs(24'h800000, 24'h800000));
    // Searching slot 0 alone from the far corner gives a large distance.
    quiesce();
    cfg_write(CFG_LM_COUNT, 24'd1);
    send_item(make_obs(24'h800000, 24'h800000));
  endtask

  // Extreme pose and heading values drive the transform into saturation
  // at the high end; a tiny heading exercises the rounding step.
  task automatic test_rotation_saturation();
    quiesce();
    cfg_write(CFG_LM_COUNT, 24'd6);
    cfg_write(CFG_POSE_X, 24'h7FFFFF);
    cfg_write(CFG_POSE_Y, 24'h800000);
    cfg_write(CFG_COS_HEADING, {8'hFF, 16'hC000});
    cfg_write(CFG_SIN_HEADING, {8'h00, 16'h4000});
    send_item(make_obs(24'h7FFFFF, 24'h000000));
    send_item(make_obs(24'h800000, 24'h800000));
    send_item(make_obs(24'h7FFFFF, 24'h7FFFFF));
    quiesce();
    cfg_write(CFG_POSE_X, 24'h800000);
    cfg_write(CFG_POSE_Y, 24'h7FFFFF);
    cfg_write(CFG_COS_HEADING, {8'hA5, 16'h0001});
    cfg_write(CFG_SIN_HEADING, {8'h5A, 16'hFFFF});
    send_item(make_obs(24'h002000, 24'hFFE000));
    send_item(make_obs(24'h800000, 24'h7FFFFF));
  endtask

  // Fill the whole table so that any count, including ones above the
  // depth, only ever reads loaded slots from here on.
  task automatic test_full_table();
    quiesce();
    cfg_write(CFG_POSE_X, 24'd0);
    cfg_write(CFG_POSE_Y, 24'd0);
    cfg_write(CFG_COS_HEADING, 24'd16384);
    cfg_write(CFG_SIN_HEADING, 24'd0);
    for (int i = 0; i < MAX_SLOTS; i++) begin
      send_item(make_load(i[5:0], rand_coord(1'($urandom_range(0, 1))),
                          rand_coord(1'($urandom_range(0, 1))), 16'($urandom())));
    end
    quiesce();
    cfg_write(CFG_LM_COUNT, 24'd64);
    for (int i = 0; i < 4; i++)
      send_item(make_obs(rand_coord(i[0]), rand_coord(i[0])));
    quiesce();
    // Count above the table depth, with noise in the unused upper bits.
    cfg_write(CFG_LM_COUNT, {17'($urandom()), 7'd127});
    for (int i = 0; i < 4; i++)
      send_item(make_obs(rand_coord(i[0]), rand_coord(i[0])));
  endtask

  // The receiver holds off for a long stretch while short observations keep
  // coming, so the output register fills, the next observation parks in its
  // last step and the input channel stalls. Afterward the sender waits for
  // every result before going on.
  task automatic test_back_pressure();
    quiesce();
    cfg_write(CFG_LM_COUNT, 24'd2);
    hold_left = HOLD_CYCLES;
    for (int i = 0; i < 10; i++)
      send_item(make_obs(rand_coord(1'b0), rand_coord(1'b0)));
    quiesce();
  endtask

  // Random phases, each with its own register setting. Even phases use an
  // identity heading so observations can be aimed at stored landmarks,
  // which makes the nearest search compete among close candidates.
  task automatic test_random_phases();
    logic [23:0] px, py, ox, oy;
    logic [15:0] ch, sh;
    logic [6:0]  cnt;
    int          pick, n;
    for (int k = 0; k < PHASES; k++) begin
      quiesce();
      calm_phase = (k == PHASES - 1);
      case ($urandom_range(0, 3))
        0:       begin px = rand_coord(1'b0); py = rand_coord(1'b0); end
        1:       begin px = rand_coord(1'b1); py = rand_coord(1'b1); end
        2:       begin px = 24'h7FFFFF;       py = 24'h800000;       end
        default: begin px = 24'h800000;       py = 24'h7FFFFF;       end
      endcase
      if (k % 2 == 0) begin
        ch = 16'd16384;
        sh = 16'd0;
      end else if (k == 1) begin
        ch = 16'd0;
        sh = 16'hC000;
      end else begin
        ch = 16'(int'($urandom_range(0, 32768)) - 16384);
        sh = 16'(int'($urandom_range(0, 32768)) - 16384);
      end
      if (k == 0)      cnt = 7'd0;
      else if (k == 1) cnt = 7'd64;
      else if (k == 2) cnt = 7'(65 + $urandom_range(0, 62));
      else             cnt = 7'($urandom_range(1, 64));
      cfg_write(CFG_POSE_X, px);
      cfg_write(CFG_POSE_Y, py);
      cfg_write(CFG_COS_HEADING, {8'($urandom()), ch});
      cfg_write(CFG_SIN_HEADING, {8'($urandom()), sh});
      cfg_write(CFG_LM_COUNT, {17'($urandom()), cnt});
      n = (int'(cnt) > MAX_SLOTS) ? MAX_SLOTS : int'(cnt);
      for (int j = 0; j < PHASE_ITEMS; j++) begin
        if ($urandom_range(0, 9) < 3) begin
          // Some loads copy another slot's position to create ties.
          pick = $urandom_range(0, MAX_SLOTS - 1);
          if ($urandom_range(0, 4) == 0)
            send_item(make_load(6'($urandom()), tbl_x[pick], tbl_y[pick], 16'($urandom())));
          else
            send_item(make_load(6'($urandom()), rand_coord(1'($urandom_range(0, 1))),
                                rand_coord(1'($urandom_range(0, 1))), 16'($urandom())));
        end else if (k % 2 == 0 && n > 0 && $urandom_range(0, 9) < 6) begin
          pick = $urandom_range(0, n - 1);
          ox = 24'(clamp_coord(longint'(tbl_x[pick]) - longint'(p_pose_x) +
                               longint'($urandom_range(0, 2047)) - 1024));
          oy = 24'(clamp_coord(longint'(tbl_y[pick]) - longint'(p_pose_y) +
                               longint'($urandom_range(0, 2047)) - 1024));
          send_item(make_obs(ox, oy));
        end else begin
          send_item(make_obs(rand_coord(1'($urandom_range(0, 1))),
                             rand_coord(1'($urandom_range(0, 1)))));
        end
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_POSE_X;
    cfg_data  = '0;
    p_pose_x  = POSE_X_RST;
    p_pose_y  = POSE_Y_RST;
    p_cos     = COS_RST;
    p_sin     = SIN_RST;
    p_count   = COUNT_RST;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_empty_table();
    test_nearest_search();
    test_rotation_saturation();
    test_full_table();
    test_back_pressure();
    test_random_phases();

    // All stimulus is in; wait for the last results and a quiet tail.
    quiesce();
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
